### design/angle_command_frame_parser_top_defines.svh
// ----------------------------------------------------------------------------
// Angle command frame parser: assertion macros
// Shared assertion wrappers used by the checker of the frame parser.
// ----------------------------------------------------------------------------
`ifndef ANGLE_COMMAND_FRAME_PARSER_TOP_DEFINES_SVH
`define ANGLE_COMMAND_FRAME_PARSER_TOP_DEFINES_SVH

// Assertion that is checked only outside reset.
`define ACFP_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Assertion that is also checked while reset is applied.
`define ACFP_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

### design/acfp_pkg.sv
// ----------------------------------------------------------------------------
// Angle command frame parser package
// Byte codes, command codes and the result item type of the frame parser.
// ----------------------------------------------------------------------------
package acfp_pkg;

   // Number of payload bytes in a frame: direction, angle high, angle low.
   localparam int PAYLOAD_LEN = 3;

   // Frame marker and type bytes.
   localparam logic [7:0] MARK_BYTE = 8'h6D;
   localparam logic [7:0] TYPE_INIT = 8'h49;
   localparam logic [7:0] TYPE_CTRL = 8'h43;
   localparam logic [7:0] TYPE_RST  = 8'h52;

   // Latched command codes.
   typedef enum logic [1:0] {
      CMD_NONE = 2'd0,
      CMD_INIT = 2'd1,
      CMD_CTRL = 2'd2,
      CMD_RST  = 2'd3
   } cmd_type;

   // One result item.
   typedef struct packed {
      logic        frame_done;
      logic        frame_error;
      cmd_type     command;
      logic [7:0]  direction;
      logic [15:0] angle;
      logic        reset_request;
   } result_type;

endpackage

### design/acfp_req_if.sv
// ----------------------------------------------------------------------------
// Request channel interface
// Carries one received byte per item with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface acfp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

### design/acfp_rsp_if.sv
// ----------------------------------------------------------------------------
// Response channel interface
// Carries one parser result per item with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface acfp_rsp_if;
   logic        valid;
   logic        ready;
   logic        frame_done;
   logic        frame_error;
   logic [1:0]  command;
   logic [7:0]  direction;
   logic [15:0] angle;
   logic        reset_request;

   modport source (output valid, output frame_done, output frame_error, output command,
                   output direction, output angle, output reset_request, input ready);
   modport sink (input valid, input frame_done, input frame_error, input command,
                 input direction, input angle, input reset_request, output ready);
endinterface

### design/angle_command_frame_parser_top.sv
// ----------------------------------------------------------------------------
// Angle command frame parser
// Recognises 'm' 'm' type payload[3] 'm' 'm' command frames in a byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one received byte per item; rsp_chan returns exactly one
//   result item per byte, in order: frame done and error pulses, the latched
//   command, direction and angle, and a reset request for a good reset frame.
//   Path: an accepted byte is registered in the input stage, parsed by the
//   core, and its result is registered in the result register, which offers
//   it on rsp_chan. Throughput: one item per cycle while rsp_chan.ready stays
//   high; the parse is a single update of a small state machine between the
//   input register and the result register.
//   Reset (synchronous, active high) empties both stages and returns the
//   parser to idle with command none and direction, angle and payload zero.
//   When the receiver holds rsp_chan.ready low, the result register keeps its
//   item, the input stage still fills once, and req_chan.ready then falls
//   until the result is taken. No byte is dropped or repeated.
// ----------------------------------------------------------------------------
module angle_command_frame_parser_top (
   input  logic       clock,
   input  logic       reset,
   acfp_req_if.sink   req_chan,
   acfp_rsp_if.source rsp_chan
);
   import acfp_pkg::*;

   logic       advance;
   logic       in_valid;
   logic [7:0] in_byte;
   result_type result;

   acfp_in_stage u_in_stage (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .advance  (advance),
      .in_valid (in_valid),
      .in_byte  (in_byte)
   );

   acfp_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step    (in_valid && advance),
      .rx_byte (in_byte),
      .result  (result)
   );

   acfp_out_stage u_out_stage (
      .clock    (clock),
      .reset    (reset),
      .in_valid (in_valid),
      .result   (result),
      .advance  (advance),
      .rsp_chan (rsp_chan)
   );
endmodule

### design/acfp_in_stage.sv
// ----------------------------------------------------------------------------
// Input stage
// Registers each accepted byte; refills whenever the stage moves forward.
// ----------------------------------------------------------------------------
module acfp_in_stage (
   input  logic       clock,
   input  logic       reset,
   acfp_req_if.sink   req_chan,
   input  logic       advance,
   output logic       in_valid,
   output logic [7:0] in_byte
);
   logic       valid_ff;
   logic       valid_in;
   logic [7:0] byte_ff;

   // The stage can take a new item when empty or when its item moves on.
   assign req_chan.ready = !valid_ff || advance;
   assign valid_in       = req_chan.ready ? req_chan.valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (req_chan.ready && req_chan.valid) begin
         byte_ff <= req_chan.rx_byte;
      end
   end

   assign in_valid = valid_ff;
   assign in_byte  = byte_ff;
endmodule

### design/acfp_core.sv
// ----------------------------------------------------------------------------
// Frame parser core
// Frame state machine and latched payload; produces one result per byte.
// ----------------------------------------------------------------------------
module acfp_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic [7:0]          rx_byte,
   output acfp_pkg::result_type result
);
   import acfp_pkg::*;

   typedef enum logic [2:0] {
      PH_IDLE    = 3'd0,
      PH_HEAD1   = 3'd1,
      PH_HEAD2   = 3'd2,
      PH_PAYLOAD = 3'd3,
      PH_TAIL1   = 3'd4,
      PH_TAIL2   = 3'd5
   } phase_type;

   localparam logic [1:0] LAST_IDX = 2'(PAYLOAD_LEN - 1);
   localparam logic [1:0] LEN_CODE = 2'(PAYLOAD_LEN);

   phase_type   phase_ff, phase_in;
   logic [1:0]  count_ff, count_in;
   logic [7:0]  bytes_ff [LAST_IDX];
   logic [7:0]  bytes_in [LAST_IDX];
   cmd_type     cmd_ff, cmd_in;
   logic [7:0]  dir_ff, dir_in;
   logic [15:0] angle_ff, angle_in;
   logic [1:0]  idx;
   logic        done;
   logic        err;

   // Next state for the byte presented this cycle.
   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      bytes_in = bytes_ff;
      cmd_in   = cmd_ff;
      dir_in   = dir_ff;
      angle_in = angle_ff;
      done     = 1'b0;
      err      = 1'b0;
      // A count at or beyond the payload length restarts at the first byte.
      idx      = (count_ff >= LEN_CODE) ? 2'd0 : count_ff;
      case (phase_ff)
         PH_IDLE: begin
            phase_in = (rx_byte == MARK_BYTE) ? PH_HEAD1 : PH_IDLE;
         end
         PH_HEAD1: begin
            phase_in = (rx_byte == MARK_BYTE) ? PH_HEAD2 : PH_IDLE;
         end
         PH_HEAD2: begin
            phase_in = PH_PAYLOAD;
            case (rx_byte)
               TYPE_INIT: cmd_in = CMD_INIT;
               TYPE_CTRL: cmd_in = CMD_CTRL;
               TYPE_RST:  cmd_in = CMD_RST;
               default: begin
                  cmd_in   = CMD_NONE;
                  phase_in = PH_IDLE;
               end
            endcase
         end
         PH_PAYLOAD: begin
            if (idx == LAST_IDX) begin
               // Last payload byte: latch direction and big-endian angle.
               count_in = 2'd0;
               phase_in = PH_TAIL1;
               dir_in   = bytes_ff[0];
               angle_in = {bytes_ff[1], rx_byte};
            end else begin
               bytes_in[idx[0]] = rx_byte;
               count_in         = idx + 2'd1;
            end
         end
         PH_TAIL1, PH_TAIL2: begin
            if (rx_byte == MARK_BYTE) begin
               phase_in = (phase_ff == PH_TAIL1) ? PH_TAIL2 : PH_IDLE;
               done     = (phase_ff == PH_TAIL2);
            end else begin
               // Bad tail: the whole frame is discarded.
               err      = 1'b1;
               phase_in = PH_IDLE;
               cmd_in   = CMD_NONE;
               dir_in   = 8'd0;
               angle_in = 16'd0;
               for (int i = 0; i < LAST_IDX; i++) begin
                  bytes_in[i] = 8'd0;
               end
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   // Parser state, updated once per byte.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         count_ff <= 2'd0;
         cmd_ff   <= CMD_NONE;
         dir_ff   <= 8'd0;
         angle_ff <= 16'd0;
         for (int i = 0; i < LAST_IDX; i++) begin
            bytes_ff[i] <= 8'd0;
         end
      end else if (step) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         cmd_ff   <= cmd_in;
         dir_ff   <= dir_in;
         angle_ff <= angle_in;
         bytes_ff <= bytes_in;
      end
   end

   // Result as seen after the update.
   always_comb begin
      result.frame_done    = done;
      result.frame_error   = err;
      result.command       = cmd_in;
      result.direction     = dir_in;
      result.angle         = angle_in;
      result.reset_request = done && (cmd_in == CMD_RST);
   end
endmodule

### design/acfp_out_stage.sv
// ----------------------------------------------------------------------------
// Output stage
// Result register driving the response channel; holds its item while stalled.
// ----------------------------------------------------------------------------
module acfp_out_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  acfp_pkg::result_type result,
   output logic                 advance,
   acfp_rsp_if.source           rsp_chan
);
   import acfp_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   result_type res_ff;

   // The pipeline moves when this register is empty or being emptied.
   assign advance  = !valid_ff || rsp_chan.ready;
   assign valid_in = advance ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (advance && in_valid) begin
         res_ff <= result;
      end
   end

   assign rsp_chan.valid         = valid_ff;
   assign rsp_chan.frame_done    = res_ff.frame_done;
   assign rsp_chan.frame_error   = res_ff.frame_error;
   assign rsp_chan.command       = res_ff.command;
   assign rsp_chan.direction     = res_ff.direction;
   assign rsp_chan.angle         = res_ff.angle;
   assign rsp_chan.reset_request = res_ff.reset_request;
endmodule

### design/acfp_checker.sv
// ----------------------------------------------------------------------------
// Frame parser checker
// Port-level assertions on the response channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "angle_command_frame_parser_top_defines.svh"

module acfp_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_frame_done,
   input logic        rsp_frame_error,
   input logic [1:0]  rsp_command,
   input logic [7:0]  rsp_direction,
   input logic [15:0] rsp_angle,
   input logic        rsp_reset_request
);
   import acfp_pkg::*;

   // No result item is offered straight after reset.
   `ACFP_ASSERT_ALWAYS(a_idle_after_reset, reset |=> !rsp_valid, "result valid after reset")

   // A reset request only comes with a completed reset frame.
   `ACFP_ASSERT(a_rst_req, rsp_valid && rsp_reset_request |-> rsp_frame_done && rsp_command == CMD_RST, "reset request without a good reset frame")

   // A discarded frame leaves nothing latched and is never also complete.
   `ACFP_ASSERT(a_discard, rsp_valid && rsp_frame_error |-> !rsp_frame_done && rsp_command == CMD_NONE && rsp_direction == 8'd0 && rsp_angle == 16'd0, "discarded frame left state behind")

   // A stalled result item stays offered and unchanged.
   `ACFP_ASSERT(a_stall_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_frame_done) && $stable(rsp_frame_error) && $stable(rsp_command) && $stable(rsp_direction) && $stable(rsp_angle), "stalled result changed")
endmodule

bind angle_command_frame_parser_top acfp_checker u_acfp_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_frame_done    (rsp_chan.frame_done),
   .rsp_frame_error   (rsp_chan.frame_error),
   .rsp_command       (rsp_chan.command),
   .rsp_direction     (rsp_chan.direction),
   .rsp_angle         (rsp_chan.angle),
   .rsp_reset_request (rsp_chan.reset_request)
);
